// File: sv/assert_macros.svh
// shared assertion helpers, clocked on clk and held off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define STAI_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

`define STAI_ASSERT_NEVER(label, cond, msg) \
	`STAI_ASSERT(label, !(cond), msg)

`endif

// File: sv/stai_pkg.sv
package stai_pkg;

	localparam int ANGLE_W = 16;
	localparam int SERVO_W = 16;
	localparam int FRAC_MAX = 16;
	// integer bits that hold every table angle and rack position
	localparam int INT_W = 6;

	localparam int TABLE_ENTRIES_DEF = 45;
	localparam int FRAC_BITS_DEF = 8;

	localparam int CAL_COUNT = 45;
	localparam longint unsigned CAL_UNIT = 64'd100000000;
	localparam longint unsigned GEAR_NUM = 64'd1000000000;
	localparam longint unsigned GEAR_DEN = 64'd555332034;
	localparam longint unsigned OUT_MAX = 64'd65535;

	localparam logic [31:0] GEAR_NUM32 = 32'(GEAR_NUM);
	localparam logic [31:0] GEAR_DEN32 = 32'(GEAR_DEN);
	localparam logic [31:0] GEAR_HALF32 = 32'(GEAR_DEN / 2);
	localparam logic [31:0] GEAR_DEN2_32 = 32'(GEAR_DEN * 2);

	// calibration, wheel angle and rack position in units of 1e-8 degree
	localparam longint unsigned CAL_WHEEL [CAL_COUNT] = '{
		64'd0, 64'd75167547, 64'd149704683, 64'd223779056, 64'd297547221,
		64'd371155658, 64'd444741611, 64'd518433761, 64'd592352754, 64'd666611580,
		64'd741315842, 64'd816563879, 64'd892446781, 64'd969048282, 64'd1046444521,
		64'd1124703686, 64'd1203885510, 64'd1284040629, 64'd1365209768, 64'd1447422745,
		64'd1530697258, 64'd1615037421, 64'd1700431988, 64'd1786852212, 64'd1874249247,
		64'd1962550967, 64'd2051658090, 64'd2141439410, 64'd2231725958, 64'd2322303921,
		64'd2412906236, 64'd2503203067, 64'd2592792095, 64'd2681191035, 64'd2767837806,
		64'd2852109147, 64'd2933376635, 64'd3011127740, 64'd3085178761, 64'd3155974958,
		64'd3224892966, 64'd3294366205, 64'd3367660784, 64'd3448311700, 64'd3539447277
	};

	localparam longint unsigned CAL_RACK [CAL_COUNT] = '{
		64'd0, 64'd164564423, 64'd327280288, 64'd488072400, 64'd646866376,
		64'd803588539, 64'd958165834, 64'd1110525747, 64'd1260596249, 64'd1408305732,
		64'd1553582958, 64'd1696357016, 64'd1836557272, 64'd1974113324, 64'd2108954962,
		64'd2241012116, 64'd2370214818, 64'd2496493141, 64'd2619777159, 64'd2739996881,
		64'd2857082192, 64'd2970962791, 64'd3081568108, 64'd3188827233, 64'd3292668818,
		64'd3393020983, 64'd3489811202, 64'd3582966179, 64'd3672411716, 64'd3758072548,
		64'd3839872177, 64'd3917732674, 64'd3991574456, 64'd4061316039, 64'd4126873750,
		64'd4188161409, 64'd4245089954, 64'd4297567025, 64'd4345496473, 64'd4388777800,
		64'd4427305510, 64'd4460968350, 64'd4489648427, 64'd4513220158, 64'd4531549040
	};

	typedef struct packed {
		logic en;
		logic valid;
	} stage_ctl_t;

	// table value to fixed point, round half up
	function automatic longint unsigned to_q(input longint unsigned v, input int unsigned f);
		return ((v << f) + CAL_UNIT / 2) / CAL_UNIT;
	endfunction

	// floor(2^s / gear ratio), low by at most one unit
	function automatic longint unsigned gear_recip(input int unsigned s);
		return (GEAR_NUM << s) / GEAR_DEN;
	endfunction

	function automatic longint unsigned gear_off(input longint unsigned rack);
		return (rack * GEAR_NUM + GEAR_DEN / 2) / GEAR_DEN;
	endfunction

endpackage

// File: sv/stai_div.sv
`include "assert_macros.svh"

module stai_div #(
	parameter int DEN_W = 14,
	parameter int SIDE_W = 16
) (
	input logic clk,
	input logic arst_n,
	input stai_pkg::stage_ctl_t ctl,
	input logic [2*DEN_W-1:0] num,
	input logic [DEN_W-1:0] den,
	input logic [SIDE_W-1:0] side,
	output logic out_valid,
	output logic [DEN_W-1:0] quot,
	output logic [SIDE_W-1:0] side_out
);
	import stai_pkg::*;

	localparam int NUM_W = 2 * DEN_W;
	localparam int STEPS = DEN_W;

	logic [NUM_W-1:0] rem_s [STEPS];
	logic [DEN_W-1:0] den_s [STEPS];
	logic [DEN_W-1:0] quot_s [STEPS];
	logic [SIDE_W-1:0] side_s [STEPS];
	logic v_s [STEPS];

	// restoring division, one quotient bit per stage, msb first
	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam int SH = STEPS - 1 - k;
		logic [NUM_W-1:0] rem_prev;
		logic [DEN_W-1:0] den_prev;
		logic [DEN_W-1:0] quot_prev;
		logic [SIDE_W-1:0] side_prev;
		logic v_prev;
		logic [NUM_W-1:0] trial;
		logic take;

		if (k == 0) begin : g_first
			assign rem_prev = num;
			assign den_prev = den;
			assign quot_prev = '0;
			assign side_prev = side;
			assign v_prev = ctl.valid;
		end else begin : g_next
			assign rem_prev = rem_s[k-1];
			assign den_prev = den_s[k-1];
			assign quot_prev = quot_s[k-1];
			assign side_prev = side_s[k-1];
			assign v_prev = v_s[k-1];
		end

		assign trial = NUM_W'(den_prev) << SH;
		assign take = rem_prev >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (ctl.en) begin
				v_s[k] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				rem_s[k] <= take ? (rem_prev - trial) : rem_prev;
				quot_s[k] <= quot_prev | (DEN_W'(take) << SH);
				den_s[k] <= den_prev;
				side_s[k] <= side_prev;
			end
		end
	end

	assign out_valid = v_s[STEPS-1];
	assign quot = quot_s[STEPS-1];
	assign side_out = side_s[STEPS-1];

	`STAI_ASSERT(a_div_rem_below_den, v_s[STEPS-1] |-> rem_s[STEPS-1] < NUM_W'(den_s[STEPS-1]), "divider remainder not below divisor")

endmodule

// File: sv/steer_angle_to_servo_interp.sv
// Steering wheel angle to servo command. Each request carries a signed wheel angle with
// FRAC_BITS fraction bits; its magnitude is clamped to the last calibration angle, interpolated
// between neighboring entries of the wheel-to-rack table, scaled by the rack gear ratio and
// centered on 90 degrees, with the sign restored and the result held to 0..180 degrees.
// The block is a straight pipeline: a new request is taken every cycle while wheel_ready is
// high, and the bulk of its stages lie in the interpolation divider, which resolves one quotient
// bit per stage. A two-deep output (the last stage plus a skid register) keeps wheel_ready
// registered; it falls only while the skid register holds a result that the consumer has not
// yet taken.
`include "assert_macros.svh"

module steer_angle_to_servo_interp #(
	parameter int TABLE_ENTRIES = stai_pkg::TABLE_ENTRIES_DEF,
	parameter int FRAC_BITS = stai_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic wheel_valid,
	output logic wheel_ready,
	input logic signed [stai_pkg::ANGLE_W-1:0] wheel_angle,
	output logic servo_valid,
	input logic servo_ready,
	output logic [stai_pkg::SERVO_W-1:0] servo_angle,
	output logic was_clamped
);
	import stai_pkg::*;

	localparam int N = (TABLE_ENTRIES < 2) ? 2 :
		((TABLE_ENTRIES > CAL_COUNT) ? CAL_COUNT : TABLE_ENTRIES);
	localparam int F = (FRAC_BITS > FRAC_MAX) ? FRAC_MAX : FRAC_BITS;
	localparam int QW = F + INT_W;
	localparam int CMP_W = (QW > ANGLE_W) ? QW : ANGLE_W;
	localparam int HI_W = $clog2(N);
	localparam int X_W = 2 * QW;
	localparam int G_W = QW + 1;
	localparam int P_W = QW + G_W;
	localparam int OFF_W = QW + 1;
	localparam int SV_W = F + 9;
	localparam int SAT_W = (SV_W > SERVO_W + 1) ? SV_W : SERVO_W + 1;
	localparam int SIDE_W = QW + 2;

	localparam logic [G_W-1:0] GEAR_G = G_W'(gear_recip(QW));
	localparam longint unsigned CENTER = 64'd90 << F;
	localparam longint unsigned FULL = 64'd180 << F;
	localparam longint unsigned OFF_END = gear_off(to_q(CAL_RACK[N-1], F));
	localparam longint unsigned POS_END = (CENTER + OFF_END > FULL) ? FULL : CENTER + OFF_END;
	localparam longint unsigned NEG_END = (OFF_END > CENTER) ? 64'd0 : CENTER - OFF_END;
	localparam logic [SERVO_W-1:0] CLAMP_POS = SERVO_W'((POS_END > OUT_MAX) ? OUT_MAX : POS_END);
	localparam logic [SERVO_W-1:0] CLAMP_NEG = SERVO_W'((NEG_END > OUT_MAX) ? OUT_MAX : NEG_END);
	localparam logic [SERVO_W-1:0] SERVO_TOP = SERVO_W'((FULL > OUT_MAX) ? OUT_MAX : FULL);
	localparam logic [SV_W-1:0] CENTER_V = SV_W'(CENTER);
	localparam logic [SV_W-1:0] FULL_V = SV_W'(FULL);

	logic [QW-1:0] wheel_q [N];
	logic [QW-1:0] rack_q [N];

	for (genvar g = 0; g < N; g++) begin : g_tab
		assign wheel_q[g] = QW'(to_q(CAL_WHEEL[g], F));
		assign rack_q[g] = QW'(to_q(CAL_RACK[g], F));
	end

	logic en;
	logic skid_v_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic v_s8, v_s9, v_s10, v_s11, v_s12;

	logic neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7;
	logic neg_s8, neg_s9, neg_s10, neg_s11;
	logic clamp_s2, clamp_s3, clamp_s4, clamp_s5, clamp_s6, clamp_s7;
	logic clamp_s8, clamp_s9, clamp_s10, clamp_s11, clamp_s12;
	logic [ANGLE_W-1:0] mag_s1, mag_s2, mag_s3, mag_s4;
	logic [N-1:0] ge_s2;
	logic [HI_W-1:0] hi_s3;
	logic [QW-1:0] wl_s4;
	logic [QW-1:0] den_s4, den_s5, den_s6, den_s7;
	logic [QW-1:0] rl_s4, rl_s5, rl_s6, rl_s7;
	logic [QW-1:0] dr_s4, dr_s5;
	logic [QW-1:0] diff_s5;
	logic [X_W-1:0] p_s6;
	logic [X_W-1:0] x_s7;
	logic [QW-1:0] rack_s8;
	logic [P_W-1:0] prod_s9;
	logic [31:0] resa_s9, resa_s10;
	logic [G_W-1:0] q0_s10;
	logic [31:0] qd_s10;
	logic [OFF_W-1:0] off_s11;
	logic [SERVO_W-1:0] servo_s12;
	logic [SERVO_W-1:0] servo_q;
	logic clamped_q;

	logic neg_in;
	logic [ANGLE_W-1:0] mag_in;
	logic [N-1:0] ge_c;
	logic clamp_c;
	logic [HI_W-1:0] hi_c;
	logic [HI_W-1:0] lo_c;
	logic v_dv;
	logic [QW-1:0] quot_dv;
	logic [SIDE_W-1:0] side_dv;
	logic [G_W-1:0] q0_c;
	logic [31:0] r_c;
	logic [SV_W-1:0] off_v;
	logic [SV_W-1:0] pos_v;
	logic [SV_W-1:0] sv_c;
	logic [SAT_W-1:0] sat_c;
	stage_ctl_t div_ctl;

	// pipeline moves whenever the skid register is free
	assign en = !skid_v_q;
	assign wheel_ready = en;

	assign neg_in = wheel_angle[ANGLE_W-1];
	assign mag_in = neg_in ? ((~$unsigned(wheel_angle)) + ANGLE_W'(1)) : $unsigned(wheel_angle);

	// thermometer of table angles at or below the magnitude, ends forced
	always_comb begin
		ge_c = '0;
		ge_c[0] = 1'b1;
		for (int i = 1; i < N - 1; i++) begin
			ge_c[i] = CMP_W'(mag_s1) >= CMP_W'(wheel_q[i]);
		end
	end
	assign clamp_c = CMP_W'(mag_s1) >= CMP_W'(wheel_q[N-1]);

	// upper segment index is where the thermometer ends
	always_comb begin
		hi_c = '0;
		for (int i = 1; i < N; i++) begin
			if (ge_s2[i-1] && !ge_s2[i]) begin
				hi_c = hi_c | HI_W'(i);
			end
		end
	end
	assign lo_c = HI_W'(hi_s3 - HI_W'(1));

	assign div_ctl = '{en: en, valid: v_s7};

	stai_div #(
		.DEN_W(QW),
		.SIDE_W(SIDE_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(div_ctl),
		.num(x_s7),
		.den(den_s7),
		.side({neg_s7, clamp_s7, rl_s7}),
		.out_valid(v_dv),
		.quot(quot_dv),
		.side_out(side_dv)
	);

	// gear scaling: reciprocal estimate, then fix up from the exact residue mod 2^32
	assign q0_c = prod_s9[P_W-1:QW];
	assign r_c = resa_s10 - qd_s10;

	assign off_v = SV_W'(off_s11);
	assign pos_v = CENTER_V + off_v;
	always_comb begin
		if (neg_s11) begin
			sv_c = (off_v > CENTER_V) ? '0 : (CENTER_V - off_v);
		end else begin
			sv_c = (pos_v > FULL_V) ? FULL_V : pos_v;
		end
	end
	assign sat_c = SAT_W'(sv_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (en) begin
				v_s1 <= wheel_valid;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
				v_s5 <= v_s4;
				v_s6 <= v_s5;
				v_s7 <= v_s6;
				v_s8 <= v_dv;
				v_s9 <= v_s8;
				v_s10 <= v_s9;
				v_s11 <= v_s10;
				v_s12 <= v_s11;
			end
			if (skid_v_q) begin
				if (servo_ready) begin
					skid_v_q <= 1'b0;
				end
			end else if (v_s12 && !servo_ready) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= neg_in;
			mag_s1 <= mag_in;

			neg_s2 <= neg_s1;
			mag_s2 <= mag_s1;
			ge_s2 <= ge_c;
			clamp_s2 <= clamp_c;

			neg_s3 <= neg_s2;
			mag_s3 <= mag_s2;
			clamp_s3 <= clamp_s2;
			hi_s3 <= hi_c;

			neg_s4 <= neg_s3;
			mag_s4 <= mag_s3;
			clamp_s4 <= clamp_s3;
			wl_s4 <= wheel_q[lo_c];
			den_s4 <= wheel_q[hi_s3] - wheel_q[lo_c];
			rl_s4 <= rack_q[lo_c];
			dr_s4 <= rack_q[hi_s3] - rack_q[lo_c];

			neg_s5 <= neg_s4;
			clamp_s5 <= clamp_s4;
			den_s5 <= den_s4;
			rl_s5 <= rl_s4;
			dr_s5 <= dr_s4;
			// clamped requests skip the interpolation, a zero keeps the divider in range
			diff_s5 <= clamp_s4 ? '0 : QW'(CMP_W'(mag_s4) - CMP_W'(wl_s4));

			neg_s6 <= neg_s5;
			clamp_s6 <= clamp_s5;
			den_s6 <= den_s5;
			rl_s6 <= rl_s5;
			p_s6 <= X_W'(diff_s5) * X_W'(dr_s5);

			neg_s7 <= neg_s6;
			clamp_s7 <= clamp_s6;
			den_s7 <= den_s6;
			rl_s7 <= rl_s6;
			x_s7 <= p_s6 + X_W'(den_s6 >> 1);

			neg_s8 <= side_dv[SIDE_W-1];
			clamp_s8 <= side_dv[SIDE_W-2];
			rack_s8 <= side_dv[SIDE_W-2] ? rack_q[N-1] : (side_dv[QW-1:0] + quot_dv);

			neg_s9 <= neg_s8;
			clamp_s9 <= clamp_s8;
			prod_s9 <= P_W'(rack_s8) * P_W'(GEAR_G);
			resa_s9 <= 32'(rack_s8) * GEAR_NUM32 + GEAR_HALF32;

			neg_s10 <= neg_s9;
			clamp_s10 <= clamp_s9;
			resa_s10 <= resa_s9;
			q0_s10 <= q0_c;
			qd_s10 <= 32'(q0_c) * GEAR_DEN32;

			neg_s11 <= neg_s10;
			clamp_s11 <= clamp_s10;
			off_s11 <= q0_s10 + OFF_W'(r_c >= GEAR_DEN32) + OFF_W'(r_c >= GEAR_DEN2_32);

			clamp_s12 <= clamp_s11;
			servo_s12 <= (sat_c > SAT_W'(OUT_MAX)) ? SERVO_W'(OUT_MAX) : SERVO_W'(sat_c);
		end
		if (!skid_v_q) begin
			servo_q <= servo_s12;
			clamped_q <= clamp_s12;
		end
	end

	assign servo_valid = skid_v_q || v_s12;
	assign servo_angle = skid_v_q ? servo_q : servo_s12;
	assign was_clamped = skid_v_q ? clamped_q : clamp_s12;

	`STAI_ASSERT(a_skid_fill_on_stall, $rose(skid_v_q) |-> $past(v_s12 && !servo_ready), "skid register filled without a stalled result")
	`STAI_ASSERT_NEVER(a_servo_range, servo_valid && (servo_angle > SERVO_TOP), "servo angle beyond full scale")
	`STAI_ASSERT(a_clamp_value, (servo_valid && was_clamped) |-> (servo_angle == CLAMP_POS || servo_angle == CLAMP_NEG), "clamped request gave a servo angle off the end stops")

endmodule
